// ===== hdl/mtre_pkg.sv =====
package mtre_pkg;

    // Tile geometry and clamps.
    localparam int TILE_PIXELS = 256;
    localparam int TILE_SHIFT  = $clog2(TILE_PIXELS);
    localparam int MAX_VIEW    = 1024;
    localparam int MAX_ZOOM    = 20;

    // Field widths.
    localparam int PX_W    = 29;
    localparam int ZOOM_W  = 5;
    localparam int VIEW_W  = 11;
    localparam int BASE_W  = PX_W - TILE_SHIFT;
    localparam int TILE_W  = 22;
    localparam int DRAW_W  = 11;
    localparam int OFF_W   = 9;
    localparam int GRID_W  = 3;

    // Stream widths.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 1;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = CFG_IDX_W'(1);

    localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = VIEW_W'(640);
    localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = VIEW_W'(480);

    localparam int HDR_QUEUE_DEPTH = 2;

    // One classified request, as handed from the front end to the cell walker.
    typedef struct packed {
        logic signed [BASE_W-1:0] base_col;
        logic signed [BASE_W-1:0] base_row;
        logic [ZOOM_W-1:0]        zoom;
        logic signed [OFF_W-1:0]  off_x;
        logic signed [OFF_W-1:0]  off_y;
        logic [GRID_W-1:0]        n_cols;
        logic [GRID_W-1:0]        n_rows;
    } t_hdr;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

endpackage

// ===== hdl/mtre_front.sv =====
module mtre_front
    import mtre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VIEW_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [S_TDATA_W-1:0] i_data,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_hdr                 o_q_hdr
);

    logic [VIEW_W-1:0] r_view_width;
    logic [VIEW_W-1:0] r_view_height;

    logic signed [PX_W-1:0] px;
    logic signed [PX_W-1:0] py;
    logic [ZOOM_W-1:0]      zoom_in;
    logic                   adj_x;
    logic                   adj_y;
    logic [VIEW_W-1:0]      view_w_clamped;
    logic [VIEW_W-1:0]      view_h_clamped;
    logic signed [VIEW_W+1:0] span_x;
    logic signed [VIEW_W+1:0] span_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width  <= VIEW_WIDTH_RST;
            r_view_height <= VIEW_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_VIEW_WIDTH:  r_view_width  <= i_cfg_data;
                CFG_VIEW_HEIGHT: r_view_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign px      = i_data[PX_W-1:0];
    assign py      = i_data[2*PX_W-1:PX_W];
    assign zoom_in = i_data[2*PX_W+ZOOM_W-1:2*PX_W];

    // A negative coordinate with a nonzero fraction rounds toward zero,
    // so the floor quotient from the shift is one too small there.
    assign adj_x = px[PX_W-1] & (|px[TILE_SHIFT-1:0]);
    assign adj_y = py[PX_W-1] & (|py[TILE_SHIFT-1:0]);

    assign view_w_clamped = (r_view_width  > VIEW_W'(MAX_VIEW)) ? VIEW_W'(MAX_VIEW) : r_view_width;
    assign view_h_clamped = (r_view_height > VIEW_W'(MAX_VIEW)) ? VIEW_W'(MAX_VIEW) : r_view_height;

    always_comb begin
        o_q_hdr.base_col = BASE_W'(px >>> TILE_SHIFT) + BASE_W'(adj_x);
        o_q_hdr.base_row = BASE_W'(py >>> TILE_SHIFT) + BASE_W'(adj_y);
        o_q_hdr.zoom     = (zoom_in > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom_in;

        // Offset is the negated truncating remainder.
        if (adj_x) begin
            o_q_hdr.off_x = OFF_W'((OFF_W+1)'(TILE_PIXELS) - (OFF_W+1)'(px[TILE_SHIFT-1:0]));
        end else begin
            o_q_hdr.off_x = OFF_W'((OFF_W+1)'(0) - (OFF_W+1)'(px[TILE_SHIFT-1:0]));
        end
        if (adj_y) begin
            o_q_hdr.off_y = OFF_W'((OFF_W+1)'(TILE_PIXELS) - (OFF_W+1)'(py[TILE_SHIFT-1:0]));
        end else begin
            o_q_hdr.off_y = OFF_W'((OFF_W+1)'(0) - (OFF_W+1)'(py[TILE_SHIFT-1:0]));
        end

        span_x = $signed({2'b00, view_w_clamped}) - (VIEW_W+2)'(o_q_hdr.off_x);
        span_y = $signed({2'b00, view_h_clamped}) - (VIEW_W+2)'(o_q_hdr.off_y);

        // A negative span is above minus one tile and truncates to zero.
        o_q_hdr.n_cols = span_x[VIEW_W+1] ? GRID_W'(1)
                                          : GRID_W'(span_x[VIEW_W+1:TILE_SHIFT] + 1'b1);
        o_q_hdr.n_rows = span_y[VIEW_W+1] ? GRID_W'(1)
                                          : GRID_W'(span_y[VIEW_W+1:TILE_SHIFT] + 1'b1);
    end

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;

endmodule

// ===== hdl/mtre_hdr_fifo.sv =====
module mtre_hdr_fifo
    import mtre_pkg::*;
#(
    parameter int DEPTH = HDR_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_hdr i_hdr,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_hdr o_hdr
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_hdr             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_hdr   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/mtre_back.sv =====
module mtre_back
    import mtre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_hdr                 i_q_hdr,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [M_TDATA_W-1:0] o_data,
    output logic [M_TUSER_W-1:0] o_user,
    output logic                 o_last
);

    t_back_state       r_state;
    t_back_state       n_state;
    t_hdr              r_hdr;
    t_hdr              n_hdr;
    logic [GRID_W-1:0] r_col;
    logic [GRID_W-1:0] n_col;
    logic [GRID_W-1:0] r_row;
    logic [GRID_W-1:0] n_row;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;
    logic              r_out_last;

    logic              advance;
    logic              load_out;
    logic              col_end;
    logic              row_end;
    logic signed [TILE_W-1:0] tile_col;
    logic signed [TILE_W-1:0] tile_row;
    logic [TILE_W-1:0] limit;
    logic              col_in;
    logic              row_in;
    logic [DRAW_W-1:0] draw_x;
    logic [DRAW_W-1:0] draw_y;

    assign advance = !r_out_valid || i_ready;
    assign col_end = (r_col == r_hdr.n_cols - 1'b1);
    assign row_end = (r_row == r_hdr.n_rows - 1'b1);

    assign tile_col = TILE_W'(r_hdr.base_col) + TILE_W'(r_col);
    assign tile_row = TILE_W'(r_hdr.base_row) + TILE_W'(r_row);
    assign limit    = TILE_W'(1) << r_hdr.zoom;
    assign col_in   = !tile_col[TILE_W-1] && (unsigned'(tile_col) < limit);
    assign row_in   = !tile_row[TILE_W-1] && (unsigned'(tile_row) < limit);
    assign draw_x   = DRAW_W'(32'(r_col) << TILE_SHIFT);
    assign draw_y   = DRAW_W'(32'(r_row) << TILE_SHIFT);

    always_comb begin
        n_state  = r_state;
        n_hdr    = r_hdr;
        n_col    = r_col;
        n_row    = r_row;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_hdr   = i_q_hdr;
                    n_col   = '0;
                    n_row   = '0;
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (advance) begin
                    load_out = 1'b1;
                    if (row_end) begin
                        n_row = '0;
                        n_col = r_col + 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                    if (row_end && col_end) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        if (load_out) begin
            r_out_data <= {(M_TDATA_W - 2*TILE_W - 2*DRAW_W - 2*OFF_W - 2*GRID_W)'(0),
                           r_hdr.n_rows, r_hdr.n_cols, r_hdr.off_y, r_hdr.off_x,
                           draw_y, draw_x, tile_row, tile_col};
            r_out_user <= M_TUSER_W'(col_in && row_in);
            r_out_last <= row_end && col_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_user;
    assign o_last  = r_out_last;

endmodule

// ===== hdl/map_tile_range_enumerator_core.sv =====
// Channel   | Direction | Transfer contents
// ----------+-----------+----------------------------------------------------------
// s_axis    | in        | one viewport request: world position and zoom
// m_axis    | out       | one grid cell per transfer, columns outer, rows inner
// cfg       | in        | register write: view_width (index 0), view_height (index 1)
//
// A request of C columns by R rows produces C*R output transfers, one per cycle
// while the output is taken; the cell walker loads each request in its idle
// state before it emits the request's first cell.
// Reset is synchronous and active low; it restores the viewport to 640 by 480.
// A small header queue lets the front end accept new requests while the walker
// is busy or stalled; the input stalls only when that queue is full.
module map_tile_range_enumerator_core
    import mtre_pkg::*;
#(
    parameter int QUEUE_DEPTH = HDR_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration writes.
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VIEW_W-1:0]    i_cfg_data,

    // Request stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // From bit 0: world_px_x (29), world_px_y (29), zoom_level (5), one zero pad bit.
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,

    // Cell stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // From bit 0: tile_col (22), tile_row (22), draw_x (11), draw_y (11),
    // scroll_off_x (9), scroll_off_y (9), grid_cols (3), grid_rows (3), six zero bits.
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // Bit 0: in_world.
    output logic [M_TUSER_W-1:0] o_m_axis_tuser,
    // Marks the final cell of a request (last_cell).
    output logic                 o_m_axis_tlast
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_hdr front_hdr;
    t_hdr queue_hdr;

    // The front end splits each coordinate into a tile index and a scroll
    // offset with round-toward-zero semantics and sizes the grid.
    mtre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_hdr     (front_hdr)
    );

    mtre_hdr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_hdr   (front_hdr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_hdr   (queue_hdr)
    );

    // The back end walks the grid and holds each cell in an output register
    // until the downstream side takes it.
    mtre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_hdr   (queue_hdr),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_user    (o_m_axis_tuser),
        .o_last    (o_m_axis_tlast)
    );

endmodule
